### sv/cws_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cws_pkg
// shared types and constants of the command line word splitter
// ---------------------------------------------------------------------------
package cws_pkg;

	// result beat kinds
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [7:0] LIMIT_MAX     = 8'd128;
	localparam logic [7:0] MAX_ARGS_RST  = 8'd100;
	localparam logic [6:0] OPEN_ARGS_MAX = 7'd127;

	// one classified byte: up to three beats, emitted in the order byte, end, done
	typedef struct packed {
		logic       has_byte;
		logic       has_end;
		logic       has_done;
		logic [7:0] data;
		logic [6:0] idx;
		logic [6:0] count;
	} entry_t;

endpackage

### sv/cws_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cws_front
// accepts command bytes, tracks quoting and argument state, classifies each byte
// ---------------------------------------------------------------------------
module cws_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              full,
	output logic              push,
	output cws_pkg::entry_t   push_entry
);

	typedef enum logic [1:0] {
		Q_PLAIN  = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} qmode_t;

	logic [7:0] max_args_q;
	qmode_t     quote_q;
	logic       esc_q;
	logic       gap_q;
	logic [6:0] open_q;

	qmode_t          quote_n;
	logic            esc_n;
	logic            gap_n;
	logic [6:0]      open_n;
	logic [7:0]      lim;
	logic            blank;
	logic            skip;
	logic [6:0]      cur;
	logic            accept;
	cws_pkg::entry_t ent;

	assign accept   = in_valid && !full;
	assign in_stall = full;
	assign lim      = (max_args_q > cws_pkg::LIMIT_MAX) ? cws_pkg::LIMIT_MAX : max_args_q;
	assign blank    = (in_byte == cws_pkg::CH_SPACE) ||
	                  ((in_byte >= cws_pkg::CH_TAB) && (in_byte <= cws_pkg::CH_CR));

	always_comb begin
		quote_n = quote_q;
		esc_n   = esc_q;
		gap_n   = gap_q;
		open_n  = open_q;
		skip    = 1'b0;
		cur     = open_q - 7'd1;
		ent     = '0;
		ent.idx = cur;
		if (lim < 8'd2) begin
			if (in_byte == cws_pkg::CH_NUL) begin
				ent.has_done = 1'b1;
				ent.idx      = '0;
				quote_n      = Q_PLAIN;
				esc_n        = 1'b0;
				gap_n        = 1'b0;
				open_n       = 7'd1;
			end
		end else if (in_byte == cws_pkg::CH_NUL) begin
			// pending backslash stays literal, then close the open argument
			ent.has_byte = esc_q;
			ent.data     = cws_pkg::CH_BSLASH;
			ent.has_end  = !gap_q;
			ent.has_done = 1'b1;
			ent.count    = open_q;
			quote_n      = Q_PLAIN;
			esc_n        = 1'b0;
			gap_n        = 1'b0;
			open_n       = 7'd1;
		end else if (quote_q != Q_PLAIN) begin
			if (esc_q) begin
				ent.has_byte = 1'b1;
				ent.data     = in_byte;
				esc_n        = 1'b0;
			end else if (in_byte == cws_pkg::CH_BSLASH) begin
				esc_n = 1'b1;
			end else if (in_byte == ((quote_q == Q_SINGLE) ? cws_pkg::CH_SQUOTE
			                                               : cws_pkg::CH_DQUOTE)) begin
				quote_n = Q_PLAIN;
			end else begin
				ent.has_byte = 1'b1;
				ent.data     = in_byte;
			end
		end else begin
			if (gap_q) begin
				if (blank) begin
					skip = 1'b1;
				end else begin
					gap_n = 1'b0;
					if (open_q < cws_pkg::OPEN_ARGS_MAX)
						open_n = open_q + 7'd1;
				end
			end
			cur     = open_n - 7'd1;
			ent.idx = cur;
			if (!skip) begin
				if ({1'b0, open_n} >= (lim - 8'd1)) begin
					// last slot takes the rest raw
					ent.has_byte = 1'b1;
					ent.data     = in_byte;
				end else if (blank) begin
					ent.has_end = 1'b1;
					gap_n       = 1'b1;
				end else if (in_byte == cws_pkg::CH_SQUOTE) begin
					quote_n = Q_SINGLE;
				end else if (in_byte == cws_pkg::CH_DQUOTE) begin
					quote_n = Q_DOUBLE;
				end else begin
					ent.has_byte = 1'b1;
					ent.data     = in_byte;
				end
			end
		end
	end

	assign push       = accept && (ent.has_byte || ent.has_end || ent.has_done);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= cws_pkg::MAX_ARGS_RST;
			quote_q    <= Q_PLAIN;
			esc_q      <= 1'b0;
			gap_q      <= 1'b0;
			open_q     <= 7'd1;
		end else if (cfg_we) begin
			max_args_q <= cfg_wdata;
			quote_q    <= Q_PLAIN;
			esc_q      <= 1'b0;
			gap_q      <= 1'b0;
			open_q     <= 7'd1;
		end else if (accept) begin
			quote_q <= quote_n;
			esc_q   <= esc_n;
			gap_q   <= gap_n;
			open_q  <= open_n;
		end
	end

endmodule

### sv/cws_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cws_fifo
// short queue of classified entries between front and back
// ---------------------------------------------------------------------------
module cws_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cws_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output cws_pkg::entry_t head_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cws_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### sv/cws_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cws_back
// expands each queued entry into its result beats through an output register
// ---------------------------------------------------------------------------
module cws_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  cws_pkg::entry_t head_entry,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte,
	output logic [6:0]      arg_index,
	output logic [6:0]      arg_count,
	output logic            last
);

	logic [2:0] sent_q;     // beats of the head entry already sent: done, end, byte
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [6:0] idx_q;
	logic [6:0] count_q;
	logic       last_q;

	logic [2:0] rem;
	logic [2:0] sel;
	logic       load;
	logic       final_beat;

	assign rem  = {head_entry.has_done, head_entry.has_end, head_entry.has_byte} & ~sent_q;
	assign sel  = rem & (~rem + 3'd1);
	assign final_beat = (rem == sel);
	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				sent_q <= final_beat ? 3'b000 : (sent_q | sel);
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= final_beat;
			if (sel[0]) begin
				kind_q  <= cws_pkg::KIND_BYTE;
				byte_q  <= head_entry.data;
				idx_q   <= head_entry.idx;
				count_q <= '0;
			end else if (sel[1]) begin
				kind_q  <= cws_pkg::KIND_END;
				byte_q  <= '0;
				idx_q   <= head_entry.idx;
				count_q <= '0;
			end else begin
				kind_q  <= cws_pkg::KIND_DONE;
				byte_q  <= '0;
				idx_q   <= '0;
				count_q <= head_entry.count;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_byte  = byte_q;
	assign arg_index = idx_q;
	assign arg_count = count_q;
	assign last      = last_q;

endmodule

### sv/command_line_word_splitter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// command_line_word_splitter
// shell style splitting of a byte stream command into arguments
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid, in_stall, in_byte): one command byte per beat,
//   a zero byte ends the command. output channel (out_valid, out_stall,
//   kind, out_byte, arg_index, arg_count, last): argument bytes, end marks
//   and a done beat with the count; last marks the final beat of one byte.
//   cfg_we with cfg_wdata writes max_args and restarts the parser; write it
//   only while no command is in flight.
// timing
//   a byte is accepted every cycle while the queue has room; its first
//   result passes through the queue and then the output register. bytes
//   with no result only update the front state. the back side emits one beat
//   per cycle while out_stall is low, so a terminator with three results
//   holds the queue head; the queue of QUEUE_DEPTH entries soaks that up.
// reset
//   arst_n clears the queue and output register; max_args returns to 100.
// stall
//   out_stall holds the output beat; the queue fills and then in_stall
//   rises, the front holding its state until the queue has room again.
// ---------------------------------------------------------------------------
module command_line_word_splitter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [6:0] arg_index,
	output logic [6:0] arg_count,
	output logic       last
);

	// front to queue
	logic            push;
	cws_pkg::entry_t push_entry;
	logic            full;

	// queue to back
	logic            pop;
	logic            head_valid;
	cws_pkg::entry_t head_entry;

	// classification and parser state
	cws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples input acceptance from output stalls
	cws_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// one beat per cycle out of the head entry while out_stall is low
	cws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.out_byte   (out_byte),
		.arg_index  (arg_index),
		.arg_count  (arg_count),
		.last       (last)
	);

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the command line word splitter
// ---------------------------------------------------------------------------
// a behavioural copy of the splitter predicts the result beats of every
// accepted command byte. a beat check pops the oldest prediction for each
// output beat and compares all five fields. a short table of directed
// bytes comes first, then random commands under a spread of max_args
// settings, with random gaps on the input side and random stalls on the
// output side. a watchdog ends the run when nothing moves for too long.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int ITEMS        = 380;  // command bytes to send in all
	localparam int PHASE_BYTES  = 8;    // least bytes per max_args phase
	localparam int DRAIN_CYCLES = 16;   // front and queue settle before a write
	localparam int STALL_LIMIT  = 2000; // cycles with no beat on either side
	localparam int LONG_WORDS   = 130;  // enough words to reach the last index
	localparam int N_PHASES     = 8;
	localparam logic [7:0] PHASE_LIMITS [N_PHASES] = '{
		8'd3, 8'd255, 8'd2, 8'd1, 8'd128, 8'd0, 8'd6, 8'd100
	};

	typedef enum logic [1:0] {
		Q_PLAIN  = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} quote_t;

	typedef enum logic {
		ROW_CFG  = 1'b0,
		ROW_BYTE = 1'b1
	} row_op_t;

	// one result beat as the splitter should present it
	typedef struct packed {
		cws_pkg::kind_t kind;
		logic [7:0]     data;
		logic [6:0]     idx;
		logic [6:0]     count;
		logic           last;
	} split_beat_t;

	// one line of the directed table; n_typed beats are given by hand
	typedef struct packed {
		row_op_t     op;
		logic [7:0]  value;
		logic [1:0]  n_typed;
		split_beat_t t0;
		split_beat_t t1;
		split_beat_t t2;
	} script_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'd0;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [6:0] arg_index;
	logic [6:0] arg_count;
	logic       last;

	command_line_word_splitter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.arg_index (arg_index),
		.arg_count (arg_count),
		.last      (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state: the register and the parser position
	logic [7:0]  lim_reg;
	quote_t      qmode;
	logic        esc_wait;
	logic        in_blank_run;
	logic [6:0]  open_cnt;

	split_beat_t pending_beats[$]; // predicted beats, oldest first
	split_beat_t typed_beats[$];   // hand-written beats for the next byte
	int          err_count = 0;
	int          bytes_counted = 0;
	int          idle_cycles = 0;

	function automatic logic is_ws(input logic [7:0] b);
		return b == cws_pkg::CH_SPACE || (b >= cws_pkg::CH_TAB && b <= cws_pkg::CH_CR);
	endfunction

	function automatic split_beat_t beat(input cws_pkg::kind_t k, input logic [7:0] d,
			input logic [6:0] i, input logic [6:0] c, input logic l = 1'b0);
		split_beat_t r;
		r.kind  = k;
		r.data  = d;
		r.idx   = i;
		r.count = c;
		r.last  = l;
		return r;
	endfunction

	function automatic script_row_t row(input row_op_t op, input logic [7:0] v,
			input logic [1:0] n = 2'd0, input split_beat_t t0 = '0,
			input split_beat_t t1 = '0, input split_beat_t t2 = '0);
		script_row_t r;
		r.op      = op;
		r.value   = v;
		r.n_typed = n;
		r.t0      = t0;
		r.t1      = t1;
		r.t2      = t2;
		return r;
	endfunction

	function automatic void parser_restart();
		qmode        = Q_PLAIN;
		esc_wait     = 1'b0;
		in_blank_run = 1'b0;
		open_cnt     = 7'd1;
	endfunction

	// beats caused by one command byte, with the parser state moved on
	function automatic void split_byte(input logic [7:0] b, ref split_beat_t res[$]);
		int         m;
		logic [6:0] cur;
		logic       skip;
		res.delete();
		m   = (lim_reg > cws_pkg::LIMIT_MAX) ? int'(cws_pkg::LIMIT_MAX) : int'(lim_reg);
		cur = open_cnt - 7'd1;
		if (m < 2) begin
			// too small a limit: only the terminator answers, with count zero
			if (b == cws_pkg::CH_NUL) begin
				res.push_back(beat(cws_pkg::KIND_DONE, 8'h00, 7'd0, 7'd0));
				parser_restart();
			end
		end else if (b == cws_pkg::CH_NUL) begin
			// a dangling escape inside quotes leaves its backslash as data
			if (esc_wait)
				res.push_back(beat(cws_pkg::KIND_BYTE, cws_pkg::CH_BSLASH, cur, 7'd0));
			if (!in_blank_run)
				res.push_back(beat(cws_pkg::KIND_END, 8'h00, cur, 7'd0));
			res.push_back(beat(cws_pkg::KIND_DONE, 8'h00, 7'd0, open_cnt));
			parser_restart();
		end else if (qmode != Q_PLAIN) begin
			if (esc_wait) begin
				res.push_back(beat(cws_pkg::KIND_BYTE, b, cur, 7'd0));
				esc_wait = 1'b0;
			end else if (b == cws_pkg::CH_BSLASH) begin
				esc_wait = 1'b1;
			end else if (b == ((qmode == Q_SINGLE) ? cws_pkg::CH_SQUOTE
			                                       : cws_pkg::CH_DQUOTE)) begin
				qmode = Q_PLAIN;
			end else begin
				res.push_back(beat(cws_pkg::KIND_BYTE, b, cur, 7'd0));
			end
		end else begin
			skip = 1'b0;
			if (in_blank_run) begin
				if (is_ws(b)) begin
					skip = 1'b1;
				end else begin
					in_blank_run = 1'b0;
					if (open_cnt < cws_pkg::OPEN_ARGS_MAX)
						open_cnt = open_cnt + 7'd1;
				end
			end
			if (!skip) begin
				cur = open_cnt - 7'd1;
				if (int'(open_cnt) >= m - 1) begin
					// last argument slot takes the rest raw
					res.push_back(beat(cws_pkg::KIND_BYTE, b, cur, 7'd0));
				end else if (is_ws(b)) begin
					res.push_back(beat(cws_pkg::KIND_END, 8'h00, cur, 7'd0));
					in_blank_run = 1'b1;
				end else if (b == cws_pkg::CH_SQUOTE) begin
					qmode = Q_SINGLE;
				end else if (b == cws_pkg::CH_DQUOTE) begin
					qmode = Q_DOUBLE;
				end else begin
					res.push_back(beat(cws_pkg::KIND_BYTE, b, cur, 7'd0));
				end
			end
		end
		if (res.size() > 0)
			res[res.size() - 1].last = 1'b1;
	endfunction

	// mostly back to back, now and then a long pause
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(12, 30);
	endfunction

	function automatic logic [7:0] ws_byte();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? cws_pkg::CH_SPACE : cws_pkg::CH_TAB + 8'(r);
	endfunction

	// anything that is neither blank nor a quote; backslash included
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (is_ws(b) || b == cws_pkg::CH_SQUOTE || b == cws_pkg::CH_DQUOTE);
		return b;
	endfunction

	// content of a quoted span: anything but its own quote and backslash
	function automatic logic [7:0] span_byte(input logic [7:0] q);
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == q || b == cws_pkg::CH_BSLASH);
		return b;
	endfunction

	function automatic void push_span(ref logic [7:0] cmd[$], input logic [7:0] q,
			input logic closed);
		int r;
		cmd.push_back(q);
		repeat ($urandom_range(0, 5)) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				cmd.push_back(cws_pkg::CH_BSLASH);
				cmd.push_back(8'($urandom_range(1, 255)));
			end else if (r == 1) begin
				cmd.push_back((q == cws_pkg::CH_SQUOTE) ? cws_pkg::CH_DQUOTE
				                                        : cws_pkg::CH_SQUOTE);
			end else if (r == 2) begin
				cmd.push_back(ws_byte());
			end else begin
				cmd.push_back(span_byte(q));
			end
		end
		if (closed)
			cmd.push_back(q);
	endfunction

	// a mostly well formed command with random content, ended by the zero byte
	function automatic void build_command(input int words, ref logic [7:0] cmd[$]);
		int         t;
		logic [7:0] q;
		cmd.delete();
		if ($urandom_range(0, 7) == 0) begin
			// line noise
			repeat ($urandom_range(1, 16))
				cmd.push_back(8'($urandom_range(1, 255)));
			cmd.push_back(cws_pkg::CH_NUL);
			return;
		end
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3))
				cmd.push_back(ws_byte());
		for (int w = 0; w < words; w++) begin
			if (w > 0)
				repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
					cmd.push_back(ws_byte());
			repeat ($urandom_range(1, 3)) begin
				t = $urandom_range(0, 3);
				if (t < 2) begin
					repeat ($urandom_range(1, 4))
						cmd.push_back(plain_byte());
				end else begin
					push_span(cmd, (t == 2) ? cws_pkg::CH_SQUOTE : cws_pkg::CH_DQUOTE, 1'b1);
				end
			end
		end
		t = $urandom_range(0, 11);
		q = $urandom_range(0, 1) ? cws_pkg::CH_SQUOTE : cws_pkg::CH_DQUOTE;
		if (t == 0) begin
			repeat ($urandom_range(1, 3))
				cmd.push_back(ws_byte());
		end else if (t == 1) begin
			push_span(cmd, q, 1'b0);
		end else if (t == 2) begin
			push_span(cmd, q, 1'b0);
			cmd.push_back(cws_pkg::CH_BSLASH);
		end else if (t == 3) begin
			cmd.push_back(cws_pkg::CH_BSLASH);
		end
		cmd.push_back(cws_pkg::CH_NUL);
	endfunction

	// one input beat; the prediction is taken at the edge that accepts it
	task automatic send_byte(input logic [7:0] b, input logic steady);
		int          gap;
		split_beat_t got[$];
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		split_byte(b, got);
		if (typed_beats.size() > 0) begin
			got = typed_beats;
			typed_beats.delete();
		end
		foreach (got[i])
			pending_beats.push_back(got[i]);
		bytes_counted++;
	endtask

	task automatic send_command(ref logic [7:0] cmd[$]);
		logic steady;
		steady = ($urandom_range(0, 3) == 0);
		foreach (cmd[j])
			send_byte(cmd[j], steady);
	endtask

	// max_args only changes with the splitter idle and drained
	task automatic set_max_args(input logic [7:0] v);
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lim_reg = v;
		parser_restart();
	endtask

	// output pacing: short stall bursts, free stretches and the odd long hold
	initial begin : sink_pacing
		int   r;
		int   len;
		logic hold;
		forever begin
			r = $urandom_range(99);
			if (r < 40) begin
				hold = 1'b0;
				len  = $urandom_range(1, 6);
			end else if (r < 75) begin
				hold = 1'b1;
				len  = $urandom_range(1, 3);
			end else if (r < 90) begin
				hold = 1'b0;
				len  = $urandom_range(20, 60);
			end else begin
				hold = 1'b1;
				len  = $urandom_range(8, 30);
			end
			repeat (len) begin
				@(posedge clk);
				out_stall <= hold;
			end
		end
	end

	// every accepted output beat against the oldest prediction
	always @(posedge clk) begin : beat_check
		split_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: kind %0d byte %02h index %0d count %0d",
					kind, out_byte, arg_index, arg_count);
				err_count++;
			end else begin
				want = pending_beats.pop_front();
				if (kind != want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					err_count++;
				end
				if (out_byte != want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, out_byte);
					err_count++;
				end
				if (arg_index != want.idx) begin
					$error("arg_index: expected %0d, got %0d", want.idx, arg_index);
					err_count++;
				end
				if (arg_count != want.count) begin
					$error("arg_count: expected %0d, got %0d", want.count, arg_count);
					err_count++;
				end
				if (last != want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					err_count++;
				end
			end
		end
	end

	// no beat on either side for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL command_line_word_splitter");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		script_row_t script[$];
		logic [7:0]  cmd[$];
		int          phase;
		int          start;
		logic        long_sent;

		// after reset: empty command, then leading blank, plain backslash,
		// escaped quote in a double span, single span after a gap
		script.push_back(row(ROW_BYTE, cws_pkg::CH_NUL, 2'd2,
			beat(cws_pkg::KIND_END, 8'h00, 7'd0, 7'd0),
			beat(cws_pkg::KIND_DONE, 8'h00, 7'd0, 7'd1, 1'b1)));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_SPACE, 2'd1,
			beat(cws_pkg::KIND_END, 8'h00, 7'd0, 7'd0, 1'b1)));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_BSLASH));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_DQUOTE));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_TAB));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_BSLASH));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_DQUOTE));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_DQUOTE));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_CR));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_SQUOTE));
		script.push_back(row(ROW_BYTE, 8'hFF));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_BSLASH));
		// backslash right before the terminator: three beats
		script.push_back(row(ROW_BYTE, cws_pkg::CH_NUL, 2'd3,
			beat(cws_pkg::KIND_BYTE, cws_pkg::CH_BSLASH, 7'd2, 7'd0),
			beat(cws_pkg::KIND_END, 8'h00, 7'd2, 7'd0),
			beat(cws_pkg::KIND_DONE, 8'h00, 7'd0, 7'd3, 1'b1)));
		// trailing blank opens nothing
		script.push_back(row(ROW_BYTE, 8'h78));
		script.push_back(row(ROW_BYTE, 8'h0C));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_NUL, 2'd1,
			beat(cws_pkg::KIND_DONE, 8'h00, 7'd0, 7'd1, 1'b1)));
		// unclosed quote runs to the end
		script.push_back(row(ROW_BYTE, cws_pkg::CH_DQUOTE));
		script.push_back(row(ROW_BYTE, 8'h0A));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_NUL));
		// limit below two: bytes swallowed, done with count zero
		script.push_back(row(ROW_CFG, 8'd0));
		script.push_back(row(ROW_BYTE, 8'h41));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_NUL, 2'd1,
			beat(cws_pkg::KIND_DONE, 8'h00, 7'd0, 7'd0, 1'b1)));
		// limit three: second argument is raw, quote kept
		script.push_back(row(ROW_CFG, 8'd3));
		script.push_back(row(ROW_BYTE, 8'h61));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_SPACE));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_DQUOTE));
		script.push_back(row(ROW_BYTE, cws_pkg::CH_NUL));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		lim_reg = cws_pkg::MAX_ARGS_RST;
		parser_restart();

		foreach (script[i]) begin
			if (script[i].op == ROW_CFG) begin
				set_max_args(script[i].value);
			end else begin
				if (script[i].n_typed > 2'd0)
					typed_beats.push_back(script[i].t0);
				if (script[i].n_typed > 2'd1)
					typed_beats.push_back(script[i].t1);
				if (script[i].n_typed > 2'd2)
					typed_beats.push_back(script[i].t2);
				send_byte(script[i].value, 1'b0);
			end
		end

		// random commands, one phase per max_args setting
		long_sent     = 1'b0;
		phase         = 0;
		while (phase < N_PHASES || bytes_counted < ITEMS) begin
			set_max_args(PHASE_LIMITS[phase % N_PHASES]);
			start = bytes_counted;
			if (PHASE_LIMITS[phase % N_PHASES] == 8'd255 && !long_sent) begin
				// one-letter words past the top slot, so the raw tail sits at index 126
				cmd.delete();
				for (int k = 0; k < LONG_WORDS; k++) begin
					if (k > 0)
						cmd.push_back(ws_byte());
					cmd.push_back(plain_byte());
				end
				cmd.push_back(cws_pkg::CH_NUL);
				send_command(cmd);
				long_sent = 1'b1;
			end
			while (bytes_counted - start < PHASE_BYTES) begin
				build_command($urandom_range(1, 3), cmd);
				send_command(cmd);
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("PASS command_line_word_splitter");
		else
			$display("FAIL command_line_word_splitter");
		$finish;
	end

endmodule
